/* design/pli_pkg.sv */
// Shared types and constants for the positional list block.
`timescale 1ns / 1ps

package pli_pkg;

   localparam int DATA_W        = 32;
   localparam int OPCODE_W      = 3;
   localparam int POSITION_W    = 7;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 7;
   localparam int CAPACITY_DEF  = 64;
   // widest cell index for the largest supported capacity (1024 cells)
   localparam int IDX_MAX_W     = 10;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_INSERT = 3'd2,
      OP_DELETE = 3'd3,
      OP_READ   = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BADPOS    = 2'd3
   } status_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                 insert_en;
      logic                 delete_en;
      logic [IDX_MAX_W-1:0] pos_idx;
   } cell_ctrl_type;

endpackage

/* design/pli_cell.sv */
// One list slot: holds an entry and shifts with its neighbours on insert or delete.
`timescale 1ns / 1ps

module pli_cell #(
   parameter int IDX = 0
) (
   input  logic                                clock,
   input  pli_pkg::cell_ctrl_type              ctrl,
   input  logic signed [pli_pkg::DATA_W-1:0]   new_value,
   input  logic signed [pli_pkg::DATA_W-1:0]   left_value,
   input  logic signed [pli_pkg::DATA_W-1:0]   right_value,
   output logic signed [pli_pkg::DATA_W-1:0]   value,
   output logic signed [pli_pkg::DATA_W-1:0]   sel_value
);
   import pli_pkg::*;

   localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert_en) begin
         if (MY_IDX == ctrl.pos_idx) begin
            value_in = new_value;
         end else if (MY_IDX > ctrl.pos_idx) begin
            value_in = left_value;
         end
      end else if (ctrl.delete_en) begin
         if (MY_IDX >= ctrl.pos_idx) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   // read tap: only the addressed slot drives the OR tree
   assign sel_value = (MY_IDX == ctrl.pos_idx) ? value_ff : '0;

endmodule

/* design/positional_list_insert_delete.sv */
// Top level: bounded positional list built as a row of shifting cells.
// Usage:
//   req_ channel carries opcode, position (1-based) and item_value; one beat
//   per command. rsp_ channel returns status, read_value and entry_count for
//   every command, one beat each, in order.
//   A command is accepted at an edge with req_valid high and req_stall low;
//   its response is registered and shows on rsp_ in the next cycle.
//   One command per cycle while req_stall is low, since each cell
//   takes its neighbour's entry in the same edge for insert and delete.
//   Read selects the addressed cell through an OR tree across the row.
//   When the receiver stalls, the response holds and req_stall rises, so no
//   further command is taken until the waiting beat leaves.
//   Reset clears the live count and the response valid; entries are not
//   cleared, as only live slots are ever read.
`timescale 1ns / 1ps

module positional_list_insert_delete #(
   parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [pli_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic [pli_pkg::POSITION_W-1:0]         req_position,
   input  logic signed [pli_pkg::DATA_W-1:0]      req_item_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pli_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [pli_pkg::DATA_W-1:0]      rsp_read_value,
   output logic [pli_pkg::COUNT_OUT_W-1:0]        rsp_entry_count
);
   import pli_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   // compare width covers both the count and the position field
   localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W + 1 : POSITION_W + 1;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [STATUS_W-1:0]       rsp_status_in;
   logic signed [DATA_W-1:0]  rsp_read_value_ff;
   logic signed [DATA_W-1:0]  rsp_read_value_in;
   logic [COUNT_OUT_W-1:0]    rsp_entry_count_ff;
   logic [COUNT_OUT_W-1:0]    rsp_entry_count_in;

   logic                      accept;
   logic                      full;
   logic                      empty;
   logic [CMP_W-1:0]          pos_ext;
   logic [CMP_W-1:0]          cnt_ext;
   logic [CMP_W-1:0]          pos_m1;
   logic [CMP_W-1:0]          cnt_out_ext;
   logic                      do_insert;
   logic                      do_delete;
   logic                      do_read;
   logic                      use_tail;
   cell_ctrl_type             ctrl;
   logic signed [DATA_W-1:0]  read_or;

   logic signed [DATA_W-1:0]  cell_value [CAPACITY];
   logic signed [DATA_W-1:0]  cell_sel   [CAPACITY];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign pos_m1  = pos_ext - CMP_W'(1);

   always_comb begin
      rsp_status_in = ST_OK;
      count_in      = count_ff;
      do_insert     = 1'b0;
      do_delete     = 1'b0;
      do_read       = 1'b0;
      use_tail      = 1'b0;
      case (req_opcode)
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_APPEND: begin
            if (full) begin
               rsp_status_in = ST_OVERFLOW;
            end else begin
               do_insert = 1'b1;
               use_tail  = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         OP_INSERT: begin
            if (full) begin
               rsp_status_in = ST_OVERFLOW;
            end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               do_insert = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (empty) begin
               rsp_status_in = ST_UNDERFLOW;
            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               do_delete = 1'b1;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (empty) begin
               rsp_status_in = ST_UNDERFLOW;
            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               do_read = 1'b1;
            end
         end
         default: begin
            rsp_status_in = ST_BADPOS;
         end
      endcase
   end

   // append is an insert at the tail slot
   always_comb begin
      ctrl.insert_en = accept & do_insert;
      ctrl.delete_en = accept & do_delete;
      ctrl.pos_idx   = use_tail ? IDX_MAX_W'(cnt_ext) : IDX_MAX_W'(pos_m1);
   end

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;
      if (k == 0) begin : g_first
         assign left_value = req_item_value;
      end else begin : g_left
         assign left_value = cell_value[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[k+1];
      end
      pli_cell #(
         .IDX (k)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (req_item_value),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[k]),
         .sel_value   (cell_sel[k])
      );
   end

   always_comb begin
      read_or = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         read_or = read_or | cell_sel[k];
      end
   end

   assign rsp_read_value_in  = do_read ? read_or : '0;
   assign cnt_out_ext        = CMP_W'(count_in);
   assign rsp_entry_count_in = cnt_out_ext[COUNT_OUT_W-1:0];
   assign rsp_valid_in       = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_read_value_ff  <= rsp_read_value_in;
         rsp_entry_count_ff <= rsp_entry_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule
